[rtl/core/cvu_pkg.sv]
// ----------------------------------------------------------------------------
// cvu_pkg: shared types and helpers of the cell velocity update core
// Field layouts, configuration snapshot, micro-op program and the
// saturating conversion from magnitude to signed fixed point.
// ----------------------------------------------------------------------------
package cvu_pkg;

   localparam int WORD_W        = 64;
   localparam int DT_W          = 63;
   localparam int FRAC_BITS_DEF = 32;
   localparam int N_IN          = 11;
   localparam int REQ_DATA_W    = N_IN * WORD_W;
   localparam int STATUS_W      = 2;
   localparam int RSP_DATA_W    = 72;
   localparam int CSR_INDEX_W   = 3;
   localparam int QUEUE_DEPTH   = 2;   // power of two, pointers wrap
   localparam int PC_W          = 4;

   localparam logic signed [WORD_W-1:0] Q_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] Q_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DZ  = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TIME_STEP = 3'd0,
      REG_CORRECTOR = 3'd1,
      REG_ADVECT    = 3'd2,
      REG_EXPLICIT  = 3'd3,
      REG_DRAG      = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [DT_W-1:0] time_step;
      logic            corrector_step;
      logic            momentum_form;
      logic            stress_explicit;
      logic            drag_has_stress;
   } cfg_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] velocity_old;
      logic signed [WORD_W-1:0] convection_old;
      logic signed [WORD_W-1:0] convection_new;
      logic signed [WORD_W-1:0] stress_divergence;
      logic signed [WORD_W-1:0] body_force;
      logic signed [WORD_W-1:0] fraction_old;
      logic signed [WORD_W-1:0] fraction_new;
      logic signed [WORD_W-1:0] fraction_half;
      logic signed [WORD_W-1:0] density_old;
      logic signed [WORD_W-1:0] density_new;
      logic signed [WORD_W-1:0] density_half;
   } item_type;

   // one queued job: the cell data and the mode it was accepted under
   typedef struct packed {
      cfg_type  mode;
      item_type item;
   } job_type;

   // result of an arithmetic unit, valid for the cycle done is high
   typedef struct packed {
      logic                     done;
      logic signed [WORD_W-1:0] val;
      logic                     sat;
      logic                     dz;
   } unit_res_type;

   typedef enum logic [1:0] {OP_END, OP_MUL, OP_DIV, OP_ADD} op_type;

   typedef enum logic [4:0] {
      S_U, S_CO, S_CN, S_TAU, S_F, S_EO, S_EN, S_EH, S_RO, S_RN, S_RH,
      S_DT, S_HALF, S_V, S_T, S_H, S_S, S_W,
      S_RW,   // drag_has_stress ? 1.0 : fraction_half
      S_DH,   // corrector ? half*dt : dt
      S_E     // drag_has_stress ? fraction_new : 1.0
   } src_type;

   typedef enum logic [2:0] {D_V, D_T, D_H, D_S, D_W} dst_type;

   // step is done always, only in predictor, only in corrector, or when
   // the stress term applies (predictor with explicit diffusion, corrector)
   typedef enum logic [1:0] {C_ALL, C_PRED, C_CORR, C_STRESS} cond_type;

   typedef struct packed {
      op_type   op;
      src_type  a;
      src_type  b;
      dst_type  dst;
      cond_type cond;
   } uop_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] val;
      logic                     sat;
   } sat_res_type;

   function automatic uop_type mk(input op_type op, input src_type a, input src_type b,
                                  input dst_type dst, input cond_type cond);
      uop_type s;
      s.op   = op;
      s.a    = a;
      s.b    = b;
      s.dst  = dst;
      s.cond = cond;
      return s;
   endfunction

   // micro-op program, convective form then momentum form
   function automatic uop_type prog_step(input logic am, input logic [PC_W-1:0] pc);
      uop_type s;
      s = mk(OP_END, S_V, S_V, D_V, C_ALL);
      if (!am) begin
         case (pc)
            4'd0:  s = mk(OP_MUL, S_EH,   S_U,   D_V, C_ALL);
            4'd1:  s = mk(OP_MUL, S_DT,   S_CO,  D_T, C_PRED);
            4'd2:  s = mk(OP_ADD, S_CO,   S_CN,  D_S, C_CORR);
            4'd3:  s = mk(OP_MUL, S_HALF, S_DT,  D_H, C_CORR);
            4'd4:  s = mk(OP_MUL, S_H,    S_S,   D_T, C_CORR);
            4'd5:  s = mk(OP_ADD, S_V,    S_T,   D_V, C_ALL);
            4'd6:  s = mk(OP_DIV, S_V,    S_EH,  D_V, C_ALL);
            4'd7:  s = mk(OP_MUL, S_RH,   S_RW,  D_W, C_ALL);
            4'd8:  s = mk(OP_MUL, S_DH,   S_TAU, D_T, C_STRESS);
            4'd9:  s = mk(OP_DIV, S_T,    S_W,   D_T, C_STRESS);
            4'd10: s = mk(OP_ADD, S_V,    S_T,   D_V, C_STRESS);
            4'd11: s = mk(OP_MUL, S_DT,   S_F,   D_T, C_ALL);
            4'd12: s = mk(OP_ADD, S_V,    S_T,   D_V, C_ALL);
            default: s = mk(OP_END, S_V, S_V, D_V, C_ALL);
         endcase
      end else begin
         case (pc)
            4'd0:  s = mk(OP_MUL, S_EO,   S_RO,  D_V, C_ALL);
            4'd1:  s = mk(OP_MUL, S_V,    S_U,   D_V, C_ALL);
            4'd2:  s = mk(OP_MUL, S_DT,   S_CO,  D_T, C_PRED);
            4'd3:  s = mk(OP_ADD, S_CO,   S_CN,  D_S, C_CORR);
            4'd4:  s = mk(OP_MUL, S_HALF, S_DT,  D_H, C_CORR);
            4'd5:  s = mk(OP_MUL, S_H,    S_S,   D_T, C_CORR);
            4'd6:  s = mk(OP_ADD, S_V,    S_T,   D_V, C_ALL);
            4'd7:  s = mk(OP_MUL, S_DH,   S_E,   D_T, C_STRESS);
            4'd8:  s = mk(OP_MUL, S_T,    S_TAU, D_T, C_STRESS);
            4'd9:  s = mk(OP_ADD, S_V,    S_T,   D_V, C_STRESS);
            4'd10: s = mk(OP_MUL, S_EN,   S_RN,  D_W, C_ALL);
            4'd11: s = mk(OP_DIV, S_V,    S_W,   D_V, C_ALL);
            4'd12: s = mk(OP_MUL, S_DT,   S_F,   D_T, C_ALL);
            4'd13: s = mk(OP_ADD, S_V,    S_T,   D_V, C_ALL);
            default: s = mk(OP_END, S_V, S_V, D_V, C_ALL);
         endcase
      end
      return s;
   endfunction

   function automatic logic [WORD_W-1:0] mag_of(input logic signed [WORD_W-1:0] x);
      return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
   endfunction

   // signed result from sign and magnitude, saturating
   function automatic sat_res_type from_mag(input logic neg, input logic hi_nz,
                                            input logic [WORD_W-1:0] lo);
      sat_res_type r;
      r.sat = hi_nz | (!neg & lo[WORD_W-1]) | (neg & (lo > WORD_W'(Q_MIN)));
      if (r.sat) begin
         r.val = neg ? Q_MIN : Q_MAX;
      end else begin
         r.val = neg ? WORD_W'(-lo) : lo;
      end
      return r;
   endfunction

endpackage

[rtl/core/cell_velocity_update_core.sv]
// ----------------------------------------------------------------------------
// The back end loads a job, walks its micro-op program one step at a time (a
// multiply, a bit-serial divide that a zero divisor ends early, an add or a
// skipped step), then hands the result off to the output register.
// One cell per program run, mostly spent in the bit-serial divider; a two-deep
// input queue takes beats meanwhile. The done state holds while the output is full.
// Reset (synchronous, active high) empties queue and output register, loads defaults.
// ----------------------------------------------------------------------------
// cell_velocity_update_core: velocity update of one cell component
// Front end queues cell beats; back end runs the fixed point update.
// ----------------------------------------------------------------------------
module cell_velocity_update_core #(
   parameter int FRAC_BITS = cvu_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // velocity_old, convection_old, convection_new, stress_divergence,
   // body_force, fraction_old, fraction_new, fraction_half, density_old,
   // density_new, density_half (64 bits each)
   input  logic [cvu_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // velocity_new [63:0], status [65:64], zero fill
   output logic [cvu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [cvu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cvu_pkg::DT_W-1:0]        csr_wdata
);
   import cvu_pkg::*;

   cfg_type                  cfg_ff;
   logic                     job_valid, job_pop;
   job_type                  job;
   logic signed [WORD_W-1:0] velocity_new;
   logic [STATUS_W-1:0]      status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step       <= '0;
         cfg_ff.corrector_step  <= 1'b0;
         cfg_ff.momentum_form   <= 1'b0;
         cfg_ff.stress_explicit <= 1'b1;
         cfg_ff.drag_has_stress <= 1'b0;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_TIME_STEP: cfg_ff.time_step       <= csr_wdata;
            REG_CORRECTOR: cfg_ff.corrector_step  <= csr_wdata[0];
            REG_ADVECT:    cfg_ff.momentum_form   <= csr_wdata[0];
            REG_EXPLICIT:  cfg_ff.stress_explicit <= csr_wdata[0];
            REG_DRAG:      cfg_ff.drag_has_stress <= csr_wdata[0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   cvu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_data  (req_tdata),
      .req_ready (req_tready),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   cvu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_velocity (velocity_new),
      .rsp_status   (status),
      .rsp_ready    (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_DATA_W - WORD_W - STATUS_W){1'b0}}, status, velocity_new};

endmodule

[rtl/core/cvu_front.sv]
// ----------------------------------------------------------------------------
// cvu_front: input side of the velocity update core
// Accepts cell beats, tags each with the current mode and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module cvu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [cvu_pkg::REQ_DATA_W-1:0] req_data,
   output logic                          req_ready,
   input  cvu_pkg::cfg_type              cfg,
   output logic                          job_valid,
   output cvu_pkg::job_type              job,
   input  logic                          job_pop
);
   import cvu_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   job_type          new_job;

   // unpack the beat, first field in the lowest bits
   always_comb begin
      new_job.mode                   = cfg;
      new_job.item.velocity_old      = req_data[0*WORD_W +: WORD_W];
      new_job.item.convection_old    = req_data[1*WORD_W +: WORD_W];
      new_job.item.convection_new    = req_data[2*WORD_W +: WORD_W];
      new_job.item.stress_divergence = req_data[3*WORD_W +: WORD_W];
      new_job.item.body_force        = req_data[4*WORD_W +: WORD_W];
      new_job.item.fraction_old      = req_data[5*WORD_W +: WORD_W];
      new_job.item.fraction_new      = req_data[6*WORD_W +: WORD_W];
      new_job.item.fraction_half     = req_data[7*WORD_W +: WORD_W];
      new_job.item.density_old       = req_data[8*WORD_W +: WORD_W];
      new_job.item.density_new       = req_data[9*WORD_W +: WORD_W];
      new_job.item.density_half      = req_data[10*WORD_W +: WORD_W];
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid & req_ready;
   assign job_valid = (count_ff != '0);
   assign job       = entry_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

[rtl/core/cvu_mul.sv]
// ----------------------------------------------------------------------------
// cvu_mul: iterative fixed point multiplier
// 64 by 64 magnitude product from four 32 by 32 partial products, then
// scaled by the fraction width and saturated.
// ----------------------------------------------------------------------------
module cvu_mul #(
   parameter int FRAC_BITS = cvu_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [cvu_pkg::WORD_W-1:0] a,
   input  logic signed [cvu_pkg::WORD_W-1:0] b,
   output cvu_pkg::unit_res_type             res
);
   import cvu_pkg::*;

   localparam int HW = WORD_W / 2;
   localparam int PW = 2 * WORD_W;

   logic [WORD_W-1:0] x_ff, y_ff;
   logic              neg_ff;
   logic              busy_ff;
   logic [2:0]        cnt_ff;
   logic [WORD_W-1:0] pp_ff;
   logic [1:0]        sh_ff;
   logic [PW-1:0]     acc_ff, acc_in;
   unit_res_type      res_ff;
   sat_res_type       fin;

   // accumulate the registered partial product at its weight
   assign acc_in = acc_ff + (PW'(pp_ff) << {sh_ff, 5'b0});
   assign fin    = from_mag(neg_ff, |acc_ff[PW-1:WORD_W+FRAC_BITS],
                            acc_ff[WORD_W+FRAC_BITS-1:FRAC_BITS]);
   assign res    = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         res_ff.done <= 1'b0;
         if (start) begin
            x_ff    <= mag_of(a);
            y_ff    <= mag_of(b);
            neg_ff  <= a[WORD_W-1] ^ b[WORD_W-1];
            acc_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff < 3'd4) begin
               pp_ff <= x_ff[HW*cnt_ff[1] +: HW] * y_ff[HW*cnt_ff[0] +: HW];
               sh_ff <= 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
            end
            if (cnt_ff != 3'd0 && cnt_ff < 3'd5) begin
               acc_ff <= acc_in;
            end
            if (cnt_ff == 3'd5) begin
               res_ff.done <= 1'b1;
               res_ff.val  <= fin.val;
               res_ff.sat  <= fin.sat;
               res_ff.dz   <= 1'b0;
               busy_ff     <= 1'b0;
            end
         end
      end
   end

endmodule

[rtl/core/cvu_div.sv]
// ----------------------------------------------------------------------------
// cvu_div: iterative fixed point divider
// Restoring radix-2 division of the scaled dividend magnitude, one quotient
// bit a cycle, with saturation and divide-by-zero handling.
// ----------------------------------------------------------------------------
module cvu_div #(
   parameter int FRAC_BITS = cvu_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [cvu_pkg::WORD_W-1:0] a,
   input  logic signed [cvu_pkg::WORD_W-1:0] b,
   output cvu_pkg::unit_res_type             res
);
   import cvu_pkg::*;

   localparam int NW = WORD_W + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]     num_ff, q_ff;
   logic [WORD_W-1:0] rem_ff, rem_in, d_ff;
   logic [WORD_W:0]   rem2, diff;
   logic              ge;
   logic              neg_ff;
   logic              busy_ff;
   logic [CW-1:0]     cnt_ff;
   unit_res_type      res_ff;
   sat_res_type       fin;

   // one restoring step
   always_comb begin
      rem2   = {rem_ff, num_ff[NW-1]};
      diff   = rem2 - {1'b0, d_ff};
      ge     = (rem2 >= {1'b0, d_ff});
      rem_in = ge ? diff[WORD_W-1:0] : rem2[WORD_W-1:0];
   end

   assign fin = from_mag(neg_ff, |q_ff[NW-1:WORD_W], q_ff[WORD_W-1:0]);
   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         res_ff.done <= 1'b0;
         if (start) begin
            if (b == '0) begin
               // zero divisor: saturate by the dividend sign
               res_ff.done <= 1'b1;
               res_ff.val  <= a[WORD_W-1] ? Q_MIN : Q_MAX;
               res_ff.sat  <= 1'b0;
               res_ff.dz   <= 1'b1;
            end else begin
               num_ff  <= {mag_of(a), {FRAC_BITS{1'b0}}};
               d_ff    <= mag_of(b);
               neg_ff  <= a[WORD_W-1] ^ b[WORD_W-1];
               rem_ff  <= '0;
               q_ff    <= '0;
               cnt_ff  <= CW'(NW);
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               rem_ff <= rem_in;
               q_ff   <= {q_ff[NW-2:0], ge};
               num_ff <= num_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               res_ff.done <= 1'b1;
               res_ff.val  <= fin.val;
               res_ff.sat  <= fin.sat;
               res_ff.dz   <= 1'b0;
               busy_ff     <= 1'b0;
            end
         end
      end
   end

endmodule

[rtl/core/cvu_back.sv]
// ----------------------------------------------------------------------------
// cvu_back: execution side of the velocity update core
// Sequencer that walks the micro-op program over a shared multiplier,
// divider and adder, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cvu_back #(
   parameter int FRAC_BITS = cvu_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  cvu_pkg::job_type                    job,
   output logic                                job_pop,
   output logic                                rsp_valid,
   output logic signed [cvu_pkg::WORD_W-1:0]   rsp_velocity,
   output logic [cvu_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                rsp_ready
);
   import cvu_pkg::*;

   localparam logic signed [WORD_W-1:0] ONE  = WORD_W'(1) << FRAC_BITS;
   localparam logic signed [WORD_W-1:0] HALF = WORD_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   job_type                  job_ff;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic signed [WORD_W-1:0] v_ff, t_ff, h_ff, s_ff, w_ff;
   logic                     sat_ff, dz_ff;
   logic                     out_valid_ff;
   logic signed [WORD_W-1:0] out_vel_ff;
   logic [STATUS_W-1:0]      out_status_ff;

   uop_type                  step;
   logic signed [WORD_W-1:0] opa, opb, wr_val;
   logic [WORD_W:0]          add_sum;
   logic                     add_sat;
   logic signed [WORD_W-1:0] add_val;
   logic                     cond_ok, wr_en, sat_set, dz_set, load, out_load;
   logic                     mul_start, div_start;
   unit_res_type             mul_res, div_res;

   // operand selection
   function automatic logic signed [WORD_W-1:0] pick(input src_type s);
      logic signed [WORD_W-1:0] r;
      case (s)
         S_U:    r = job_ff.item.velocity_old;
         S_CO:   r = job_ff.item.convection_old;
         S_CN:   r = job_ff.item.convection_new;
         S_TAU:  r = job_ff.item.stress_divergence;
         S_F:    r = job_ff.item.body_force;
         S_EO:   r = job_ff.item.fraction_old;
         S_EN:   r = job_ff.item.fraction_new;
         S_EH:   r = job_ff.item.fraction_half;
         S_RO:   r = job_ff.item.density_old;
         S_RN:   r = job_ff.item.density_new;
         S_RH:   r = job_ff.item.density_half;
         S_DT:   r = {1'b0, job_ff.mode.time_step};
         S_HALF: r = HALF;
         S_V:    r = v_ff;
         S_T:    r = t_ff;
         S_H:    r = h_ff;
         S_S:    r = s_ff;
         S_W:    r = w_ff;
         S_RW:   r = job_ff.mode.drag_has_stress ? ONE : job_ff.item.fraction_half;
         S_DH:   r = job_ff.mode.corrector_step ? h_ff : {1'b0, job_ff.mode.time_step};
         S_E:    r = job_ff.mode.drag_has_stress ? job_ff.item.fraction_new : ONE;
         default: r = '0;
      endcase
      return r;
   endfunction

   assign step = prog_step(job_ff.mode.momentum_form, pc_ff);

   // operands follow the working registers as well as the step
   always_comb begin
      opa = pick(step.a);
      opb = pick(step.b);
   end

   // step condition from the job mode
   always_comb begin
      case (step.cond)
         C_ALL:    cond_ok = 1'b1;
         C_PRED:   cond_ok = !job_ff.mode.corrector_step;
         C_CORR:   cond_ok = job_ff.mode.corrector_step;
         C_STRESS: cond_ok = job_ff.mode.corrector_step | job_ff.mode.stress_explicit;
         default:  cond_ok = 1'b0;
      endcase
   end

   // saturating adder
   always_comb begin
      add_sum = {opa[WORD_W-1], opa} + {opb[WORD_W-1], opb};
      add_sat = add_sum[WORD_W] ^ add_sum[WORD_W-1];
      add_val = add_sat ? (add_sum[WORD_W] ? Q_MIN : Q_MAX) : add_sum[WORD_W-1:0];
   end

   cvu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (opa),
      .b     (opb),
      .res   (mul_res)
   );

   cvu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .a     (opa),
      .b     (opb),
      .res   (div_res)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      wr_en     = 1'b0;
      wr_val    = add_val;
      sat_set   = 1'b0;
      dz_set    = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      job_pop   = 1'b0;
      load      = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               load     = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (step.op == OP_END) begin
               state_in = ST_DONE;
            end else if (!cond_ok) begin
               pc_in = pc_ff + 1'b1;
            end else begin
               case (step.op)
                  OP_ADD: begin
                     wr_en   = 1'b1;
                     sat_set = add_sat;
                     pc_in   = pc_ff + 1'b1;
                  end
                  OP_MUL: begin
                     mul_start = 1'b1;
                     state_in  = ST_MUL;
                  end
                  OP_DIV: begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_res.done) begin
               wr_en    = 1'b1;
               wr_val   = mul_res.val;
               sat_set  = mul_res.sat;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               wr_en    = 1'b1;
               wr_val   = div_res.val;
               sat_set  = div_res.sat;
               dz_set   = div_res.dz;
               pc_in    = pc_ff + 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // working registers and flags
   always_ff @(posedge clock) begin
      pc_ff <= pc_in;
      if (load) begin
         job_ff <= job;
         pc_ff  <= '0;
         sat_ff <= 1'b0;
         dz_ff  <= 1'b0;
      end else begin
         if (sat_set) sat_ff <= 1'b1;
         if (dz_set)  dz_ff  <= 1'b1;
      end
      if (wr_en) begin
         case (step.dst)
            D_V:     v_ff <= wr_val;
            D_T:     t_ff <= wr_val;
            D_H:     h_ff <= wr_val;
            D_S:     s_ff <= wr_val;
            D_W:     w_ff <= wr_val;
            default: v_ff <= wr_val;
         endcase
      end
      if (out_load) begin
         out_vel_ff    <= v_ff;
         out_status_ff <= dz_ff ? STATUS_DZ : (sat_ff ? STATUS_SAT : STATUS_OK);
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_velocity = out_vel_ff;
   assign rsp_status   = out_status_ff;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cell velocity update core
// Sends cell beats and writes the mode registers between phases. Each
// accepted cell is run through a fixed point predictor kept in the bench.
// Every response beat is checked against the oldest expected result. Random
// gaps and stalls on both sides, plus one long response hold.
// ----------------------------------------------------------------------------
module tb;
   import cvu_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 2000;
   localparam logic signed [63:0] ONE_Q  = 64'sh1_0000_0000;
   localparam logic signed [63:0] HALF_Q = 64'sh8000_0000;

   // field positions within a cell beat, lowest first
   localparam int F_U = 0, F_CO = 1, F_CN = 2, F_TAU = 3, F_F = 4, F_EO = 5,
                  F_EN = 6, F_EH = 7, F_RO = 8, F_RN = 9, F_RH = 10;

   typedef logic signed [63:0] cell_type [N_IN];

   typedef struct {
      logic signed [63:0]   vel;
      logic [STATUS_W-1:0]  st;
   } update_type;

   typedef struct {
      cell_type   vals;
      bit         typed;
      update_type want;
   } row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [DT_W-1:0]         csr_wdata = '0;

   cell_velocity_update_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench copy of the mode registers
   logic [DT_W-1:0] m_dt;
   bit m_corr, m_mom, m_expl, m_drag;

   update_type pending_updates[$];
   int      n_errors;
   bit      quiet_phase;
   bit      hold_request;
   int      idle_cycles;

   // ---------------- fixed point predictor ----------------
   bit sat_seen, dz_seen;

   function automatic logic [63:0] mag(input logic signed [63:0] x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic signed [63:0] to_signed(input bit neg, input logic [127:0] m);
      if (m[127:64] != 0 || (!neg && m[63]) || (neg && m[63:0] > 64'h8000_0000_0000_0000))
      begin
         sat_seen = 1;
         return neg ? Q_MIN : Q_MAX;
      end
      return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
   endfunction

   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a, b);
      logic [127:0] p;
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      return to_signed((a < 0) != (b < 0), p >> 32);
   endfunction

   function automatic logic signed [63:0] fx_div(input logic signed [63:0] a, b);
      logic [127:0] n;
      if (b == 0) begin
         dz_seen = 1;
         return a < 0 ? Q_MIN : Q_MAX;
      end
      n = {64'b0, mag(a)} << 32;
      return to_signed((a < 0) != (b < 0), n / {64'b0, mag(b)});
   endfunction

   function automatic logic signed [63:0] fx_add(input logic signed [63:0] a, b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(Q_MAX)) begin
         sat_seen = 1;
         return Q_MAX;
      end
      if (s < 65'(Q_MIN)) begin
         sat_seen = 1;
         return Q_MIN;
      end
      return s[63:0];
   endfunction

   function automatic update_type velocity_update(input cell_type c);
      logic signed [63:0] v, dt, rop, e;
      update_type r;
      sat_seen = 0;
      dz_seen  = 0;
      dt = {1'b0, m_dt};
      if (!m_mom) begin
         v = fx_mul(c[F_EH], c[F_U]);
         if (!m_corr) v = fx_add(v, fx_mul(dt, c[F_CO]));
         else v = fx_add(v, fx_mul(fx_mul(HALF_Q, dt), fx_add(c[F_CO], c[F_CN])));
         v = fx_div(v, c[F_EH]);
         rop = m_drag ? fx_mul(c[F_RH], ONE_Q) : fx_mul(c[F_RH], c[F_EH]);
         if (!m_corr) begin
            if (m_expl) v = fx_add(v, fx_div(fx_mul(dt, c[F_TAU]), rop));
         end else begin
            v = fx_add(v, fx_div(fx_mul(fx_mul(dt, HALF_Q), c[F_TAU]), rop));
         end
      end else begin
         e = m_drag ? c[F_EN] : ONE_Q;
         v = fx_mul(fx_mul(c[F_EO], c[F_RO]), c[F_U]);
         if (!m_corr) begin
            v = fx_add(v, fx_mul(dt, c[F_CO]));
            if (m_expl) v = fx_add(v, fx_mul(fx_mul(dt, e), c[F_TAU]));
         end else begin
            v = fx_add(v, fx_mul(fx_mul(dt, HALF_Q), fx_add(c[F_CO], c[F_CN])));
            v = fx_add(v, fx_mul(fx_mul(fx_mul(HALF_Q, dt), e), c[F_TAU]));
         end
         v = fx_div(v, fx_mul(c[F_EN], c[F_RN]));
      end
      v = fx_add(v, fx_mul(dt, c[F_F]));
      r.vel = v;
      r.st  = dz_seen ? STATUS_DZ : (sat_seen ? STATUS_SAT : STATUS_OK);
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic logic signed [63:0] rand_word(input bit weight);
      logic signed [63:0] w;
      case ($urandom_range(9))
         0:       w = {$urandom, $urandom};
         1:       w = 0;
         2:       w = $urandom_range(1) ? Q_MAX : Q_MIN;
         3:       w = ONE_Q;
         4:       w = -$signed({32'b0, $urandom});
         default: w = $signed({{28{1'b0}}, 4'($urandom), $urandom})
                     * ($urandom_range(1) ? 1 : -1);
      endcase
      // fractions and densities are mostly positive, near unity
      if (weight && $urandom_range(9) < 7) w = {30'b0, 2'($urandom_range(1, 3)), $urandom};
      return w;
   endfunction

   function automatic cell_type rand_cell();
      cell_type c;
      for (int i = 0; i < N_IN; i++) c[i] = rand_word(i >= F_EO);
      return c;
   endfunction

   task automatic write_reg(input csr_reg_type idx, input logic [DT_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_TIME_STEP: m_dt   = val;
         REG_CORRECTOR: m_corr = val[0];
         REG_ADVECT:    m_mom  = val[0];
         REG_EXPLICIT:  m_expl = val[0];
         REG_DRAG:      m_drag = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_cell(input cell_type c);
      int gap;
      logic [REQ_DATA_W-1:0] packed_beat;
      gap = quiet_phase ? 0 : $urandom_range(7);
      for (int i = 0; i < N_IN; i++) packed_beat[i*WORD_W +: WORD_W] = c[i];
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= packed_beat;
      do @(posedge clock); while (!req_tready);
      pending_updates.push_back(velocity_update(c));
   endtask

   task automatic drain();
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      n_errors++;
   endtask

   // ---------------- response side ----------------
   initial begin
      update_type w;
      int n;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            n = quiet_phase ? 0 : $urandom_range(7);
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_updates.size() == 0) begin
            report("unexpected beat", rsp_tdata[63:0], 64'd0);
         end else begin
            w = pending_updates.pop_front();
            if (rsp_tdata[63:0] !== w.vel) report("velocity_new", rsp_tdata[63:0], w.vel);
            if (rsp_tdata[65:64] !== w.st) report("status", 64'(rsp_tdata[65:64]), 64'(w.st));
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      row_type rows[$];
      row_type r;
      logic [DT_W-1:0] dt_pick;
      n_errors = 0;
      quiet_phase = 0;
      hold_request = 0;
      m_dt = '0; m_corr = 0; m_mom = 0; m_expl = 1; m_drag = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows under the reset mode: dt is zero
      for (int k = 0; k < 14; k++) begin
         foreach (r.vals[i]) r.vals[i] = 0;
         r.typed = 0;
         case (k)
            0: begin   // all zero: divide by zero wins over saturation
               r.typed = 1; r.want.vel = Q_MAX; r.want.st = STATUS_DZ;
            end
            1, 2: begin   // unit weights pass the velocity through
               r.vals[F_U] = (k == 1) ? Q_MAX : Q_MIN;
               r.vals[F_EH] = ONE_Q; r.vals[F_RH] = ONE_Q;
               r.typed = 1; r.want.vel = r.vals[F_U]; r.want.st = STATUS_OK;
            end
            3: begin   // product overflows
               r.vals[F_U] = Q_MAX; r.vals[F_EH] = 64'sh2_0000_0000;
               r.vals[F_RH] = ONE_Q;
            end
            default: r.vals = rand_cell();
         endcase
         rows.push_back(r);
      end
      foreach (rows[k]) begin
         if (rows[k].typed) begin
            send_cell(rows[k].vals);
            void'(pending_updates.pop_back());
            pending_updates.push_back(rows[k].want);
         end else begin
            send_cell(rows[k].vals);
         end
      end
      req_tvalid <= 1'b0;
      drain();

      // random phases, each under its own mode
      for (int ph = 0; ph < 18; ph++) begin
         case (ph)
            0:       dt_pick = '1;
            1:       dt_pick = '0;
            2:       dt_pick = 63'h1_0000_0000;
            default: dt_pick = ($urandom_range(3) == 0) ? 63'({$urandom, $urandom})
                               : 63'({$urandom_range(3), $urandom});
         endcase
         write_reg(REG_TIME_STEP, dt_pick);
         write_reg(REG_CORRECTOR, DT_W'(ph[0]));
         write_reg(REG_ADVECT, DT_W'(ph[1]));
         write_reg(REG_EXPLICIT, DT_W'((ph < 8) ? ph[2] : 1'($urandom_range(1))));
         write_reg(REG_DRAG, DT_W'((ph < 8) ? ph[2] ^ ph[0] : 1'($urandom_range(1))));
         quiet_phase = (ph == 5);
         if (ph == 7) hold_request = 1;
         for (int j = 0; j < 52; j++) begin
            send_cell(rand_cell());
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (n_errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
